// ===== rtl/mlp_forward_pass_sigmoid_defines.svh =====
// ----------------------------------------------------------------------------
// mlp_forward_pass_sigmoid_defines
// Assertion macros used by the perceptron top level; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_PASS_SIGMOID_DEFINES_SVH
`define MLP_FORWARD_PASS_SIGMOID_DEFINES_SVH

`ifndef SYNTH
`define MLPFS_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mlpfs: assertion failed");
`else
`define MLPFS_ASSERT_CLK(lbl, clk, rst_n, prop)
`endif

`ifndef SYNTH
`define MLPFS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mlpfs: reset assertion failed");
`else
`define MLPFS_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== rtl/mlpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpfs_pkg
// Sizes, types, register indexes, saturation and the sigmoid lookup table
// of the two-layer perceptron.
// ----------------------------------------------------------------------------
package mlpfs_pkg;

    localparam int INPUTS          = 2;
    localparam int HIDDEN          = 2;
    localparam int SIGMOID_ENTRIES = 256;
    localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);

    localparam int Q_W        = 16;
    localparam int ACC_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int IH_W_W     = 64;
    localparam int HB_W       = 32;
    localparam int HO_W_W     = 32;
    localparam int ERR_W      = 17;

    typedef logic signed [Q_W-1:0]   t_q412;
    typedef logic        [Q_W-1:0]   t_q016;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [SIG_IDX_W-1:0]    t_sig_idx;
    typedef logic [Q_W-1:0]          t_sig_rom [SIGMOID_ENTRIES];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IH_WEIGHTS = 2'd0,
        CFG_H_BIASES   = 2'd1,
        CFG_HO_WEIGHTS = 2'd2,
        CFG_O_BIAS     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                        vld;
        t_q016                       goal;
        logic [HIDDEN-1:0][Q_W-1:0]  act;
    } t_hid_bus;

    function automatic t_q412 sat_q412(input t_acc v);
        if (v > 22'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -22'sd32768) begin
            return 16'sh8000;
        end
        return $signed(v[Q_W-1:0]);
    endfunction

    function automatic t_sig_idx sig_idx(input t_q412 a);
        logic [Q_W-1:0] u;
        u = {~a[Q_W-1], a[Q_W-2:0]};
        return u[Q_W-1 -: SIG_IDX_W];
    endfunction

    // shift-subtract long division, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-t/4096) in Q1.31: series of exp(-y/16), then square four times
    function automatic logic [63:0] exp_neg(input logic [63:0] t);
        logic [63:0]        z;
        logic [63:0]        term;
        logic [63:0]        a;
        logic signed [63:0] sum;
        z    = t << 15;
        term = 64'd1 << 31;
        sum  = $signed(term);
        for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * z) >> 31, 64'(k));
            if ((k & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        a = $unsigned(sum);
        for (int r = 0; r < 4; r++) begin
            a = (a * a + (64'd1 << 30)) >> 31;
        end
        return a;
    endfunction

    function automatic t_q016 sigmoid_q(input logic signed [63:0] m);
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        mag = (m < 0) ? $unsigned(-m) : $unsigned(m);
        e   = exp_neg(mag);
        den = (64'd1 << 31) + e;
        if (m >= 0) begin
            s = udiv64((64'd1 << 47) + (den >> 1), den);
        end else begin
            s = udiv64((e << 16) + (den >> 1), den);
        end
        return (s > 64'd65535) ? 16'hFFFF : s[Q_W-1:0];
    endfunction

    // entry i holds the sigmoid of its bucket midpoint
    function automatic t_sig_rom sig_rom_build();
        t_sig_rom           rom;
        logic signed [63:0] m;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            m      = $signed((64'(2 * i + 1) << 15) >> SIG_IDX_W) - 64'sd32768;
            rom[i] = sigmoid_q(m);
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = sig_rom_build();

endpackage

// ===== rtl/mlpfs_hidden.sv =====
// ----------------------------------------------------------------------------
// mlpfs_hidden
// Hidden layer: products, biased sums with saturation, sigmoid lookup.
// Three register stages.
// ----------------------------------------------------------------------------
module mlpfs_hidden (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  mlpfs_pkg::t_q412      i_x [mlpfs_pkg::INPUTS],
    input  mlpfs_pkg::t_q016      i_goal,
    input  logic [mlpfs_pkg::IH_W_W-1:0] i_ih_weights,
    input  logic [mlpfs_pkg::HB_W-1:0]   i_h_biases,
    output mlpfs_pkg::t_hid_bus   o_bus
);
    import mlpfs_pkg::*;

    logic               r_a_vld;
    t_q016              r_a_goal;
    logic signed [31:0] r_a_prod [INPUTS][HIDDEN];
    logic signed [31:0] n_a_prod [INPUTS][HIDDEN];

    logic               r_b_vld;
    t_q016              r_b_goal;
    t_sig_idx           r_b_idx [HIDDEN];
    t_sig_idx           n_b_idx [HIDDEN];
    t_acc               n_b_acc [HIDDEN];

    logic               r_c_vld;
    t_q016              r_c_goal;
    t_q016              r_c_act [HIDDEN];

    always_comb begin
        for (int i = 0; i < INPUTS; i++) begin
            for (int j = 0; j < HIDDEN; j++) begin
                n_a_prod[i][j] = i_x[i] * $signed(i_ih_weights[Q_W*(i*HIDDEN+j) +: Q_W]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < HIDDEN; j++) begin
            n_b_acc[j] = t_acc'($signed(i_h_biases[Q_W*j +: Q_W]));
            for (int i = 0; i < INPUTS; i++) begin
                n_b_acc[j] = n_b_acc[j] + t_acc'(r_a_prod[i][j] >>> 12);
            end
            n_b_idx[j] = sig_idx(sat_q412(n_b_acc[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_goal <= i_goal;
        r_a_prod <= n_a_prod;
        r_b_goal <= r_a_goal;
        r_b_idx  <= n_b_idx;
        r_c_goal <= r_b_goal;
        for (int j = 0; j < HIDDEN; j++) begin
            r_c_act[j] <= SIG_ROM[r_b_idx[j]];
        end
    end

    always_comb begin
        o_bus.vld  = r_c_vld;
        o_bus.goal = r_c_goal;
        for (int j = 0; j < HIDDEN; j++) begin
            o_bus.act[j] = r_c_act[j];
        end
    end

endmodule

// ===== rtl/mlpfs_output.sv =====
// ----------------------------------------------------------------------------
// mlpfs_output
// Output neuron: weighted hidden activations, biased sum with saturation,
// sigmoid lookup and error against the goal. Three register stages.
// ----------------------------------------------------------------------------
module mlpfs_output (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mlpfs_pkg::t_hid_bus          i_bus,
    input  logic [mlpfs_pkg::HO_W_W-1:0] i_ho_weights,
    input  mlpfs_pkg::t_q412             i_o_bias,
    output logic                         o_vld,
    output mlpfs_pkg::t_q016             o_prediction,
    output logic signed [mlpfs_pkg::ERR_W-1:0] o_error
);
    import mlpfs_pkg::*;

    logic               r_d_vld;
    t_q016              r_d_goal;
    logic signed [32:0] r_d_prod [HIDDEN];
    logic signed [32:0] n_d_prod [HIDDEN];

    logic               r_e_vld;
    t_q016              r_e_goal;
    t_sig_idx           r_e_idx;
    t_acc               n_e_acc;

    logic               r_f_vld;
    t_q016              r_f_pred;
    logic [ERR_W-1:0]   r_f_err;
    t_q016              n_f_pred;

    always_comb begin
        for (int j = 0; j < HIDDEN; j++) begin
            n_d_prod[j] = $signed({1'b0, i_bus.act[j]}) * $signed(i_ho_weights[Q_W*j +: Q_W]);
        end
    end

    always_comb begin
        n_e_acc = t_acc'(i_o_bias);
        for (int j = 0; j < HIDDEN; j++) begin
            n_e_acc = n_e_acc + t_acc'(r_d_prod[j] >>> 16);
        end
    end

    assign n_f_pred = SIG_ROM[r_e_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_d_vld <= i_bus.vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_goal <= i_bus.goal;
        r_d_prod <= n_d_prod;
        r_e_goal <= r_d_goal;
        r_e_idx  <= sig_idx(sat_q412(n_e_acc));
        r_f_pred <= n_f_pred;
        r_f_err  <= {1'b0, r_e_goal} - {1'b0, n_f_pred};
    end

    assign o_vld        = r_f_vld;
    assign o_prediction = r_f_pred;
    assign o_error      = $signed(r_f_err);

endmodule

// ===== rtl/mlp_forward_pass_sigmoid.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_pass_sigmoid
// Two-layer perceptron forward pass with sigmoid activations. A request
// (start high, busy low) is taken every clock cycle; its prediction and
// error appear with o_valid after the six-stage pipeline, one result per
// request, in order. The pipeline has three stages per layer, each
// holding one multiply, one sum or one table read.
// Results are shown for one cycle and cannot be held off. busy is high
// only during reset. Write weights and biases only while no request is
// in flight.
// ----------------------------------------------------------------------------
`include "mlp_forward_pass_sigmoid_defines.svh"

module mlp_forward_pass_sigmoid (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mlpfs_pkg::t_q412                 i_x0,
    input  mlpfs_pkg::t_q412                 i_x1,
    input  mlpfs_pkg::t_q016                 i_goal,
    input  logic                             i_cfg_we,
    input  logic [mlpfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mlpfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_valid,
    output mlpfs_pkg::t_q016                 o_prediction,
    output logic signed [mlpfs_pkg::ERR_W-1:0] o_error
);
    import mlpfs_pkg::*;

    logic [IH_W_W-1:0] r_ih_weights;
    logic [HB_W-1:0]   r_h_biases;
    logic [HO_W_W-1:0] r_ho_weights;
    t_q412             r_o_bias;

    t_q412             w_x [INPUTS];
    logic              w_accept;
    t_hid_bus          w_hid;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_comb begin
        for (int i = 0; i < INPUTS; i++) begin
            w_x[i] = (i == 0) ? i_x0 : i_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih_weights <= '0;
            r_h_biases   <= '0;
            r_ho_weights <= '0;
            r_o_bias     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IH_WEIGHTS: begin
                    r_ih_weights <= i_cfg_data[IH_W_W-1:0];
                end
                CFG_H_BIASES: begin
                    r_h_biases <= i_cfg_data[HB_W-1:0];
                end
                CFG_HO_WEIGHTS: begin
                    r_ho_weights <= i_cfg_data[HO_W_W-1:0];
                end
                CFG_O_BIAS: begin
                    r_o_bias <= $signed(i_cfg_data[Q_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    mlpfs_hidden u_hidden (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_accept),
        .i_x          (w_x),
        .i_goal       (i_goal),
        .i_ih_weights (r_ih_weights),
        .i_h_biases   (r_h_biases),
        .o_bus        (w_hid)
    );

    mlpfs_output u_output (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bus        (w_hid),
        .i_ho_weights (r_ho_weights),
        .i_o_bias     (r_o_bias),
        .o_vld        (o_valid),
        .o_prediction (o_prediction),
        .o_error      (o_error)
    );

    `MLPFS_ASSERT_CLK(a_result_follows_request, i_clk, i_rst_n, o_valid |-> $past(w_accept, 6))
    `MLPFS_ASSERT_CLK(a_error_matches_goal, i_clk, i_rst_n, o_valid |-> (17'(o_error + {1'b0, o_prediction}) == {1'b0, $past(i_goal, 6)}))
    `MLPFS_ASSERT_RST(a_reset_drops_results, i_clk, !i_rst_n |=> !o_valid)

endmodule
